/* rtl/abb_pkg.sv */
// Shared types, constants and helpers for the alpha blend blit engine.
package abb_pkg;

  localparam int MAX_DIM_DEFAULT = 512;

  localparam int PIX_W   = 32;
  localparam int ADDR_W  = 18;
  localparam int DIM_W   = 10;
  localparam int STRD_W  = 10;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 18;

  localparam logic [IDX_W-1:0] REG_BLEND_ENABLE = 3'd0;
  localparam logic [IDX_W-1:0] REG_RECT_WIDTH   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RECT_HEIGHT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_BASE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_DST_STRIDE   = 3'd4;

  localparam logic [7:0] CHAN_MAX = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;
  } abb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  out_pixel;
    logic [ADDR_W-1:0] write_address;
    logic              last_pixel;
  } abb_out_t;

  typedef struct packed {
    logic take;
    logic mix;
    logic emit;
  } abb_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREM = 3'b010,
    ST_MIX  = 3'b100
  } abb_state_t;

  // floor(x / 255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

/* rtl/abb_ctrl.sv */
// Controller state machine sequencing each request through the datapath.
module abb_ctrl import abb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output abb_cmd_t   cmd,
  output abb_state_t state
);

  abb_state_t state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    cmd.take = (state == ST_IDLE) && in_valid;
    cmd.mix  = (state == ST_PREM);
    cmd.emit = (state == ST_MIX) && slot_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PREM;
      end
      ST_PREM: state_next = ST_MIX;
      ST_MIX: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = cmd.emit || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/abb_datapath.sv */
// Datapath: configuration registers, raster counters, blend arithmetic, output register.
module abb_datapath import abb_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  abb_cmd_t         cmd,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  abb_in_t          in_data,
  output abb_out_t         out_data
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int EXT_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;

  function automatic logic [CNT_W-1:0] dim_m1(input logic [DIM_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (v == '0) return '0;
    else if (ext > EXT_W'(MAX_DIM)) return CNT_W'(MAX_DIM - 1);
    else return CNT_W'(ext - EXT_W'(1));
  endfunction

  logic              blend_enable;
  logic [DIM_W-1:0]  rect_width;
  logic [DIM_W-1:0]  rect_height;
  logic [ADDR_W-1:0] dst_base;
  logic [STRD_W-1:0] dst_stride;

  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  row_count;
  logic [ADDR_W-1:0] row_address;

  logic [CNT_W-1:0]  width_m1;
  logic [CNT_W-1:0]  height_m1;
  logic              row_end;
  logic              last;
  logic              counters_zero;

  logic [PIX_W-1:0]  src_q;
  logic [PIX_W-1:0]  dst_q;
  logic [ADDR_W-1:0] addr_q;
  logic              last_q;

  logic [7:0]        a1_q;
  logic [7:0]        a2_q;
  logic [7:0]        c1_q [3];
  logic [7:0]        c2_q [3];

  logic [7:0]        inv;
  logic [PIX_W-1:0]  blend_pixel;

  assign width_m1      = dim_m1(rect_width);
  assign height_m1     = dim_m1(rect_height);
  assign row_end       = column_count >= width_m1;
  assign last          = row_end && (row_count >= height_m1);
  assign counters_zero = (column_count == '0) && (row_count == '0);

  // configuration and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_enable <= 1'b0;
      rect_width   <= DIM_W'(1);
      rect_height  <= DIM_W'(1);
      dst_base     <= '0;
      dst_stride   <= STRD_W'(512);
      column_count <= '0;
      row_count    <= '0;
      row_address  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BLEND_ENABLE: blend_enable <= cfg_data[0];
          REG_RECT_WIDTH:   rect_width   <= cfg_data[DIM_W-1:0];
          REG_RECT_HEIGHT:  rect_height  <= cfg_data[DIM_W-1:0];
          REG_DST_BASE: begin
            dst_base <= cfg_data[ADDR_W-1:0];
            if (counters_zero) row_address <= cfg_data[ADDR_W-1:0];
          end
          REG_DST_STRIDE:   dst_stride   <= cfg_data[STRD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        if (last) begin
          column_count <= '0;
          row_count    <= '0;
          row_address  <= dst_base;
        end else if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + CNT_W'(1);
          row_address  <= row_address + ADDR_W'(dst_stride);
        end else begin
          column_count <= column_count + CNT_W'(1);
        end
      end
    end
  end

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      src_q  <= in_data.src_pixel;
      dst_q  <= in_data.dst_pixel;
      addr_q <= row_address + ADDR_W'(column_count);
      last_q <= last;
    end
  end

  // premultiply
  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      a1_q <= src_q[31:24];
      a2_q <= dst_q[31:24];
      for (int i = 0; i < 3; i++) begin
        c1_q[i] <= div255(16'(src_q[8*i +: 8]) * 16'(src_q[31:24]));
        c2_q[i] <= div255(16'(dst_q[8*i +: 8]) * 16'(dst_q[31:24]));
      end
    end
  end

  // combine
  assign inv = CHAN_MAX - a1_q;

  always_comb begin
    blend_pixel[31:24] = a1_q + div255(16'(inv) * 16'(a2_q));
    for (int i = 0; i < 3; i++) begin
      blend_pixel[8*i +: 8] = c1_q[i] + div255(16'(inv) * 16'(c2_q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.out_pixel     <= blend_enable ? blend_pixel : src_q;
      out_data.write_address <= addr_q;
      out_data.last_pixel    <= last_q;
    end
  end

endmodule

/* rtl/alpha_blend_blit_core.sv */
// Top level of the alpha blend blit engine: controller plus datapath.
// A request passes through the capture, premultiply and combine steps before
// out_valid rises; a stalled output holds the combine step until the output register frees up.
// A new pixel is accepted only once the previous one has left the combine step.
// Reset: synchronous; clears counters and state.
module alpha_blend_blit_core import abb_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  abb_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output abb_out_t         out_data,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  abb_cmd_t   cmd;
  abb_state_t state;

  abb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .state     (state)
  );

  abb_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data)
  );

  a_take_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> in_stall)
    else $error("request accepted while busy");

  a_take_to_mix: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> ##2 (state == ST_MIX))
    else $error("request did not reach combine step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule
